>>> rtl/moi_pkg.sv
// Shared types, constants and tables for the mecanum odometry integrator.
package moi_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_N = 30;

	localparam logic [23:0] SCALE_RESET = 24'd40960;

	// binary angle per mrad*ms, Q16
	localparam logic [33:0] ANG_PER_MRAD_MS = 34'd44798134;

	// 0.6072529 in Q30
	localparam logic [33:0] CORDIC_X0 = 34'd652032875;

	localparam logic [23:0] WZ_MAX = 24'h7FFFFF;
	localparam logic [23:0] WZ_MIN = 24'h800000;

	localparam int MAC_AW = 25;
	localparam int MAC_BW = 34;
	localparam int MAC_PW = MAC_AW + MAC_BW;
	localparam int ACC_W = 80;

	localparam int K_SHIFT = 20;
	localparam int T_SHIFT = 24;

	typedef enum logic [1:0] {
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_mode_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_K,
		SH_T
	} mac_shift_t;

	typedef struct packed {
		logic              en;
		mac_mode_t         mode;
		mac_shift_t        shift;
		logic [MAC_AW-1:0] a;
		logic [MAC_BW-1:0] b;
	} mac_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WZ_MUL,
		ST_WZ_WAIT,
		ST_WZ_SAT,
		ST_P_MUL,
		ST_P_WAIT,
		ST_K_LO,
		ST_K_HI,
		ST_K_WAIT,
		ST_HEAD,
		ST_ROT_START,
		ST_ROT_WAIT,
		ST_X_A,
		ST_X_B,
		ST_X_WAIT,
		ST_X_TLO,
		ST_X_THI,
		ST_X_TWAIT,
		ST_X_DONE,
		ST_Y_A,
		ST_Y_B,
		ST_Y_WAIT,
		ST_Y_TLO,
		ST_Y_THI,
		ST_Y_TWAIT,
		ST_Y_DONE,
		ST_OUT
	} state_t;

	// atan(2^-i) as a binary angle, 2^32 per turn
	function automatic logic [33:0] atan_lut(input logic [4:0] idx);
		logic [33:0] v;
		case (idx)
			5'd0:  v = 34'h020000000;
			5'd1:  v = 34'h012E4051E;
			5'd2:  v = 34'h009FB385B;
			5'd3:  v = 34'h0051111D4;
			5'd4:  v = 34'h0028B0D43;
			5'd5:  v = 34'h00145D7E1;
			5'd6:  v = 34'h000A2F61E;
			5'd7:  v = 34'h000517C55;
			5'd8:  v = 34'h00028BE53;
			5'd9:  v = 34'h000145F2F;
			5'd10: v = 34'h0000A2F98;
			5'd11: v = 34'h0000517CC;
			5'd12: v = 34'h000028BE6;
			5'd13: v = 34'h0000145F3;
			5'd14: v = 34'h00000A2FA;
			5'd15: v = 34'h00000517D;
			5'd16: v = 34'h0000028BE;
			5'd17: v = 34'h00000145F;
			5'd18: v = 34'h000000A30;
			5'd19: v = 34'h000000518;
			5'd20: v = 34'h00000028C;
			5'd21: v = 34'h000000146;
			5'd22: v = 34'h0000000A3;
			5'd23: v = 34'h000000051;
			5'd24: v = 34'h000000029;
			5'd25: v = 34'h000000014;
			5'd26: v = 34'h00000000A;
			5'd27: v = 34'h000000005;
			5'd28: v = 34'h000000003;
			5'd29: v = 34'h000000001;
			default: v = 34'h000000000;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/moi_mac.sv
// Shared signed multiply-accumulate unit: registered product, then shifted accumulate.
module moi_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  moi_pkg::mac_op_t              op,
	output logic [moi_pkg::ACC_W-1:0]     acc
);

	logic signed [moi_pkg::MAC_PW-1:0] prod_s1;
	logic                              en_s1;
	moi_pkg::mac_mode_t                mode_s1;
	moi_pkg::mac_shift_t               shift_s1;

	logic [moi_pkg::ACC_W-1:0] ext;
	logic [moi_pkg::ACC_W-1:0] term;
	logic [moi_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= op.en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= $signed(op.a) * $signed(op.b);
		mode_s1  <= op.mode;
		shift_s1 <= op.shift;
	end

	assign ext = {{(moi_pkg::ACC_W-moi_pkg::MAC_PW){prod_s1[moi_pkg::MAC_PW-1]}}, prod_s1};

	always_comb begin
		case (shift_s1)
			moi_pkg::SH_NONE: term = ext;
			moi_pkg::SH_K:    term = ext << moi_pkg::K_SHIFT;
			moi_pkg::SH_T:    term = ext << moi_pkg::T_SHIFT;
			default:          term = ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			case (mode_s1)
				moi_pkg::MAC_LOAD: acc_q <= term;
				moi_pkg::MAC_ADD:  acc_q <= acc_q + term;
				moi_pkg::MAC_SUB:  acc_q <= acc_q - term;
				default:           acc_q <= term;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/moi_cordic.sv
// Rotation-mode CORDIC, one iteration per cycle, for sine and cosine in Q30.
module moi_cordic #(
	parameter int STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] ang,
	output logic        done,
	output logic [33:0] cos_v,
	output logic [33:0] sin_v
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                 busy_q;
	logic                 done_q;
	logic                 flip_q;
	logic [IW-1:0]        i_q;
	logic signed [33:0]   x_q;
	logic signed [33:0]   y_q;
	logic signed [33:0]   z_q;

	logic                 flip;
	logic [31:0]          ang_rot;
	logic signed [33:0]   dx;
	logic signed [33:0]   dy;
	logic signed [33:0]   at;

	// heading outside the right half plane: turn by a half turn first
	assign flip    = ang[31] ^ ang[30];
	assign ang_rot = ang ^ {flip, 31'd0};

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed(moi_pkg::atan_lut(5'(i_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (i_q == IW'(STEPS - 1))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed(moi_pkg::CORDIC_X0);
			y_q    <= '0;
			z_q    <= $signed({{2{ang_rot[31]}}, ang_rot});
			flip_q <= flip;
			i_q    <= '0;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
			i_q <= i_q + 1'b1;
		end
	end

	assign done  = done_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

>>> rtl/mecanum_odometry_integrator_unit.sv
// Mecanum wheel odometry integrator: body velocities, heading and world pose.
//
// Input stream s_*: one transfer per update. s_tuser selects clear (1) or
// update (0); s_tdata carries four wheel speeds and the time step. Output
// stream m_*: one result per input, pose, heading and body velocities.
// cfg_*: write of yaw_rate_scale, taken at any time, always ready; write it
// only while the block is idle.
//
// For an update, a shared 25x34 multiply-accumulate unit runs twelve
// products in sequence (yaw rate, rate times step, the heading step in two
// halves, four rotated velocity terms and four time-scaling halves), and
// the CORDIC unit runs between the heading step and the rotated terms.
// s_tready is high only while the sequencer is idle, so a new item is not
// taken until the previous one has been handed to the output register.
//
// A result sits in an output register until taken; the next item is taken
// and worked on meanwhile, and the sequencer holds its finished result until
// the register frees up. Reset zeroes the pose and heading, drops any pending
// result and restores yaw_rate_scale to its default.
module mecanum_odometry_integrator_unit #(
	parameter int CORDIC_STEPS = moi_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// speed_left_front[15:0], speed_right_front[31:16], speed_left_rear[47:32],
	// speed_right_rear[63:48], step_ms[79:64]
	input  logic [79:0]  s_tdata,
	// func: 0 update, 1 clear
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x[47:0], pos_y[95:48], yaw[127:96], body_vx[143:128],
	// body_vy[159:144], body_wz[183:160]
	output logic [183:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [23:0]  cfg_data
);

	localparam int AW = moi_pkg::MAC_AW;
	localparam int BW = moi_pkg::MAC_BW;

	moi_pkg::state_t  state_q;
	moi_pkg::state_t  state_d;
	moi_pkg::mac_op_t mac_op;

	logic [moi_pkg::ACC_W-1:0] acc;

	logic [23:0]  scale_q;
	logic [47:0]  world_x_q;
	logic [47:0]  world_y_q;
	logic [31:0]  heading_q;
	logic [15:0]  vx_q;
	logic [15:0]  vy_q;
	logic [17:0]  ys_q;
	logic [15:0]  dt_q;
	logic [23:0]  wz_q;
	logic [39:0]  p_q;
	logic [48:0]  t_q;
	logic [33:0]  c_q;
	logic [33:0]  s_q;
	logic         m_valid_q;
	logic [183:0] m_data_q;

	logic         rot_start;
	logic         rot_done;
	logic [33:0]  rot_cos;
	logic [33:0]  rot_sin;

	logic [17:0]  w1;
	logic [17:0]  w2;
	logic [17:0]  w3;
	logic [17:0]  w4;
	logic [17:0]  sum_x;
	logic [17:0]  sum_y;
	logic [17:0]  sum_z;
	logic [47:0]  wz_full;
	logic         out_free;
	logic         out_write;

	assign w1 = {{2{s_tdata[15]}}, s_tdata[15:0]};
	assign w2 = {{2{s_tdata[31]}}, s_tdata[31:16]};
	assign w3 = {{2{s_tdata[47]}}, s_tdata[47:32]};
	assign w4 = {{2{s_tdata[63]}}, s_tdata[63:48]};

	assign sum_x = w1 + w2 + w3 + w4;
	assign sum_y = w2 + w3 - w1 - w4;
	assign sum_z = w2 + w4 - w1 - w3;

	assign wz_full  = acc[63:16];
	assign out_free = !m_valid_q || m_tready;
	assign out_write = (state_q == moi_pkg::ST_OUT) && out_free;

	assign s_tready  = (state_q == moi_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	moi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	moi_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.ang    (heading_q),
		.done   (rot_done),
		.cos_v  (rot_cos),
		.sin_v  (rot_sin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= moi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mac_op       = '0;
		mac_op.mode  = moi_pkg::MAC_LOAD;
		mac_op.shift = moi_pkg::SH_NONE;
		rot_start    = 1'b0;
		case (state_q)
			moi_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? moi_pkg::ST_OUT : moi_pkg::ST_WZ_MUL;
				end
			end
			moi_pkg::ST_WZ_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'($signed(ys_q));
				mac_op.b  = BW'(scale_q);
				state_d   = moi_pkg::ST_WZ_WAIT;
			end
			moi_pkg::ST_WZ_WAIT: state_d = moi_pkg::ST_WZ_SAT;
			moi_pkg::ST_WZ_SAT:  state_d = moi_pkg::ST_P_MUL;
			moi_pkg::ST_P_MUL: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'($signed(wz_q));
				mac_op.b  = BW'(dt_q);
				state_d   = moi_pkg::ST_P_WAIT;
			end
			moi_pkg::ST_P_WAIT: state_d = moi_pkg::ST_K_LO;
			moi_pkg::ST_K_LO: begin
				// heading step split as low 20 bits unsigned plus signed high part
				mac_op.en = 1'b1;
				mac_op.a  = AW'(acc[19:0]);
				mac_op.b  = moi_pkg::ANG_PER_MRAD_MS;
				state_d   = moi_pkg::ST_K_HI;
			end
			moi_pkg::ST_K_HI: begin
				mac_op.en    = 1'b1;
				mac_op.mode  = moi_pkg::MAC_ADD;
				mac_op.shift = moi_pkg::SH_K;
				mac_op.a     = AW'($signed(p_q[39:20]));
				mac_op.b     = moi_pkg::ANG_PER_MRAD_MS;
				state_d      = moi_pkg::ST_K_WAIT;
			end
			moi_pkg::ST_K_WAIT:    state_d = moi_pkg::ST_HEAD;
			moi_pkg::ST_HEAD:      state_d = moi_pkg::ST_ROT_START;
			moi_pkg::ST_ROT_START: begin
				rot_start = 1'b1;
				state_d   = moi_pkg::ST_ROT_WAIT;
			end
			moi_pkg::ST_ROT_WAIT: begin
				if (rot_done) begin
					state_d = moi_pkg::ST_X_A;
				end
			end
			moi_pkg::ST_X_A: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'($signed(vx_q));
				mac_op.b  = c_q;
				state_d   = moi_pkg::ST_X_B;
			end
			moi_pkg::ST_X_B: begin
				mac_op.en   = 1'b1;
				mac_op.mode = moi_pkg::MAC_SUB;
				mac_op.a    = AW'($signed(vy_q));
				mac_op.b    = s_q;
				state_d     = moi_pkg::ST_X_WAIT;
			end
			moi_pkg::ST_X_WAIT: state_d = moi_pkg::ST_X_TLO;
			moi_pkg::ST_X_TLO: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'(acc[23:0]);
				mac_op.b  = BW'(dt_q);
				state_d   = moi_pkg::ST_X_THI;
			end
			moi_pkg::ST_X_THI: begin
				mac_op.en    = 1'b1;
				mac_op.mode  = moi_pkg::MAC_ADD;
				mac_op.shift = moi_pkg::SH_T;
				mac_op.a     = t_q[48:24];
				mac_op.b     = BW'(dt_q);
				state_d      = moi_pkg::ST_X_TWAIT;
			end
			moi_pkg::ST_X_TWAIT: state_d = moi_pkg::ST_X_DONE;
			moi_pkg::ST_X_DONE:  state_d = moi_pkg::ST_Y_A;
			moi_pkg::ST_Y_A: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'($signed(vx_q));
				mac_op.b  = s_q;
				state_d   = moi_pkg::ST_Y_B;
			end
			moi_pkg::ST_Y_B: begin
				mac_op.en   = 1'b1;
				mac_op.mode = moi_pkg::MAC_ADD;
				mac_op.a    = AW'($signed(vy_q));
				mac_op.b    = c_q;
				state_d     = moi_pkg::ST_Y_WAIT;
			end
			moi_pkg::ST_Y_WAIT: state_d = moi_pkg::ST_Y_TLO;
			moi_pkg::ST_Y_TLO: begin
				mac_op.en = 1'b1;
				mac_op.a  = AW'(acc[23:0]);
				mac_op.b  = BW'(dt_q);
				state_d   = moi_pkg::ST_Y_THI;
			end
			moi_pkg::ST_Y_THI: begin
				mac_op.en    = 1'b1;
				mac_op.mode  = moi_pkg::MAC_ADD;
				mac_op.shift = moi_pkg::SH_T;
				mac_op.a     = t_q[48:24];
				mac_op.b     = BW'(dt_q);
				state_d      = moi_pkg::ST_Y_TWAIT;
			end
			moi_pkg::ST_Y_TWAIT: state_d = moi_pkg::ST_Y_DONE;
			moi_pkg::ST_Y_DONE:  state_d = moi_pkg::ST_OUT;
			moi_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = moi_pkg::ST_IDLE;
				end
			end
			default: state_d = moi_pkg::ST_IDLE;
		endcase
	end

	// configuration register and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= moi_pkg::SCALE_RESET;
			world_x_q <= '0;
			world_y_q <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_valid) begin
				scale_q <= cfg_data;
			end
			case (state_q)
				moi_pkg::ST_IDLE: begin
					if (s_tvalid && s_tuser) begin
						world_x_q <= '0;
						world_y_q <= '0;
						heading_q <= '0;
					end
				end
				moi_pkg::ST_HEAD:   heading_q <= heading_q + acc[47:16];
				moi_pkg::ST_X_DONE: world_x_q <= world_x_q + acc[77:30];
				moi_pkg::ST_Y_DONE: world_y_q <= world_y_q + acc[77:30];
				default: ;
			endcase
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			moi_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser) begin
						vx_q <= '0;
						vy_q <= '0;
						wz_q <= '0;
					end else begin
						vx_q <= sum_x[17:2];
						vy_q <= sum_y[17:2];
					end
					ys_q <= sum_z;
					dt_q <= s_tdata[79:64];
				end
			end
			moi_pkg::ST_WZ_SAT: begin
				// saturate the yaw rate to 24 bits
				if (!wz_full[47] && (|wz_full[46:23])) begin
					wz_q <= moi_pkg::WZ_MAX;
				end else if (wz_full[47] && !(&wz_full[46:23])) begin
					wz_q <= moi_pkg::WZ_MIN;
				end else begin
					wz_q <= wz_full[23:0];
				end
			end
			moi_pkg::ST_K_LO:  p_q <= acc[39:0];
			moi_pkg::ST_ROT_WAIT: begin
				if (rot_done) begin
					c_q <= rot_cos;
					s_q <= rot_sin;
				end
			end
			moi_pkg::ST_X_TLO: t_q <= acc[48:0];
			moi_pkg::ST_Y_TLO: t_q <= acc[48:0];
			default: ;
		endcase
	end

	// output register: load a finished result, drop it when transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_write) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_write) begin
			m_data_q <= {wz_q, vy_q, vx_q, heading_q, world_y_q, world_x_q};
		end
	end

endmodule
